// ===== design/lu_decompose_partial_pivot_core_macros.svh =====
// Assertion macros for the LU decomposition core.
// Depends on nothing; included by the top level.
`ifndef LU_DECOMPOSE_PARTIAL_PIVOT_CORE_MACROS_SVH
`define LU_DECOMPOSE_PARTIAL_PIVOT_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LU_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define LU_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define LU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/lu_dec_pkg.sv =====
// Shared types and constants of the LU decomposition core.
// No dependencies.
`default_nettype none
package lu_dec_pkg;
	localparam int MaxOrder = 8;
	localparam int FracBits = 16;
	localparam int WordBits = 32;
	localparam int IoBits   = 32;

	localparam logic [1:0] KIND_WRITE  = 2'd0;
	localparam logic [1:0] KIND_START  = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;
endpackage
`default_nettype wire

// ===== design/lu_dec_div.sv =====
// Sequential restoring divider: saturated fixed-point quotient (a << F) / b.
// Depends on lu_dec_pkg.
`default_nettype none
module lu_dec_div #(
	parameter int WORD_BITS = lu_dec_pkg::WordBits,
	parameter int FRAC_BITS = lu_dec_pkg::FracBits
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire lu_dec_pkg::div_ctl_t   ctl_in,
	input  wire signed [WORD_BITS-1:0]  num,
	input  wire signed [WORD_BITS-1:0]  den,
	output logic                        done,
	output logic signed [WORD_BITS-1:0] quot
);
	localparam int NB = WORD_BITS + FRAC_BITS;
	localparam int CW = $clog2(NB + 1);

	logic [NB-1:0]      num_q;
	logic [NB-1:0]      q_q;
	logic [WORD_BITS:0] rem_q;
	logic [WORD_BITS:0] d_q;
	logic               neg_q;
	logic [CW-1:0]      cnt_q;
	logic               run_q;
	logic [WORD_BITS:0] rs;
	logic [WORD_BITS:0] lim;
	logic [NB-1:0]      qm;
	logic [WORD_BITS:0] nm;

	function automatic logic [WORD_BITS:0] magf(input logic signed [WORD_BITS-1:0] x);
		logic [WORD_BITS:0] e;
		e = {x[WORD_BITS-1], x};
		return x[WORD_BITS-1] ? (~e + 1'b1) : e;
	endfunction

	assign rs = {rem_q[WORD_BITS-1:0], num_q[NB-1]};
	assign nm = magf(num);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (ctl_in.start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NB);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			num_q <= {nm[WORD_BITS-1:0], {FRAC_BITS{1'b0}}};
			d_q   <= magf(den);
			rem_q <= '0;
			q_q   <= '0;
			neg_q <= num[WORD_BITS-1] ^ den[WORD_BITS-1];
		end else if (run_q) begin
			num_q <= num_q << 1;
			if (rs >= d_q) begin
				rem_q <= rs - d_q;
				q_q   <= {q_q[NB-2:0], 1'b1};
			end else begin
				rem_q <= rs;
				q_q   <= {q_q[NB-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		lim = neg_q ? {2'b01, {(WORD_BITS-1){1'b0}}} : {2'b00, {(WORD_BITS-1){1'b1}}};
		qm = q_q;
		if ((NB)'(qm) > (NB)'(lim)) qm = NB'(lim);
		quot = neg_q ? WORD_BITS'(~qm + 1'b1) : WORD_BITS'(qm);
	end
endmodule
`default_nettype wire

// ===== design/lu_decompose_partial_pivot_core.sv =====
// LU decomposition core with partial pivoting, Q16.16 fixed point.
// Writes: one word per cycle while idle and in_stall is low. Reads: the request is registered
// in rd_pend_s1, then the result words and out_valid; input stalls while a read is in flight.
// Start: init copies the matrix into L and U, then per column k a pivot search and row swap,
// a serial divide per sub-diagonal element and an update per trailing element, then the status word.
// Reset (arst_n low) clears control and status and sets matrix_size to 8; memories are not cleared.
`default_nettype none
module lu_decompose_partial_pivot_core #(
	parameter int MAX_ORDER = lu_dec_pkg::MaxOrder,
	parameter int FRAC_BITS = lu_dec_pkg::FracBits,
	parameter int WORD_BITS = lu_dec_pkg::WordBits
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_we,
	input  wire [3:0]          cfg_wdata,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire [1:0]          kind,
	input  wire [2:0]          row,
	input  wire [2:0]          col,
	input  wire signed [31:0]  value,
	output logic               out_valid,
	input  wire                out_stall,
	output logic               status,
	output logic signed [31:0] lower_value,
	output logic signed [31:0] upper_value,
	output logic [2:0]         perm_row
);
`include "lu_decompose_partial_pivot_core_macros.svh"
	localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int AW = 2 * IW;
	localparam int CELLS = MAX_ORDER * MAX_ORDER;
	localparam int NW = $clog2(MAX_ORDER + 1);
	localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam logic signed [WORD_BITS-1:0] ONE =
		(FRAC_BITS >= WORD_BITS - 1) ? WMAX : WORD_BITS'(64'd1 << FRAC_BITS);

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_INIT  = 14'b00000000000010,
		S_SRCH  = 14'b00000000000100,
		S_SWAPA = 14'b00000000001000,
		S_SWAPB = 14'b00000000010000,
		S_DIAG  = 14'b00000000100000,
		S_DRD   = 14'b00000001000000,
		S_DIV   = 14'b00000010000000,
		S_URD   = 14'b00000100000000,
		S_UPRA  = 14'b00001000000000,
		S_UPRB  = 14'b00010000000000,
		S_UPM   = 14'b00100000000000,
		S_UPW   = 14'b01000000000000,
		S_DONE  = 14'b10000000000000
	} st_t;

	// memories: work matrix, L, U (single write, registered read)
	logic signed [WORD_BITS-1:0] wm_mem [CELLS];
	logic signed [WORD_BITS-1:0] lm_mem [CELLS];
	logic signed [WORD_BITS-1:0] um_mem [CELLS];
	logic [IW-1:0]               pm_q   [MAX_ORDER];

	st_t            st_q;
	logic [3:0]     size_q;
	logic           sing_q;
	logic [NW-1:0]  n_c;
	logic [IW-1:0]  k_q, i_q, j_q, piv_q;
	logic [1:0]     ph_q;
	logic [WORD_BITS:0] best_q;
	logic           found_q;
	logic signed [WORD_BITS-1:0] diag_q, lik_q, ukj_q, t_q, prod_q;

	logic           wm_we, lm_we, um_we;
	logic [AW-1:0]  wm_wa, lm_wa, um_wa, wm_ra, lm_ra, um_ra;
	logic signed [WORD_BITS-1:0] wm_wd, lm_wd, um_wd, wm_rd, lm_rd, um_rd;

	logic           rd_pend_s1;
	logic           rd_ok_s1;
	logic [IW-1:0]  rrow_s1;

	lu_dec_pkg::div_ctl_t dctl;
	logic           d_done;
	logic signed [WORD_BITS-1:0] d_quot;

	always_ff @(posedge clk) begin
		if (wm_we) wm_mem[wm_wa] <= wm_wd;
		if (lm_we) lm_mem[lm_wa] <= lm_wd;
		if (um_we) um_mem[um_wa] <= um_wd;
		wm_rd <= wm_mem[wm_ra];
		lm_rd <= lm_mem[lm_ra];
		um_rd <= um_mem[um_ra];
	end

	lu_dec_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .ctl_in(dctl), .num(wm_rd), .den(diag_q),
		.done(d_done), .quot(d_quot)
	);

	function automatic logic [AW-1:0] ad(input logic [IW-1:0] r, input logic [IW-1:0] c);
		return AW'(r) * AW'(MAX_ORDER) + AW'(c);
	endfunction

	function automatic logic [WORD_BITS:0] magw(input logic signed [WORD_BITS-1:0] x);
		logic [WORD_BITS:0] e;
		e = {x[WORD_BITS-1], x};
		return x[WORD_BITS-1] ? (~e + 1'b1) : e;
	endfunction

	function automatic logic signed [31:0] o32(input logic signed [WORD_BITS-1:0] v);
		logic signed [63:0] e;
		e = 64'(v);
		if (e > 64'sd2147483647) return 32'sh7fffffff;
		if (e < -64'sd2147483648) return 32'sh80000000;
		return e[31:0];
	endfunction

	always_comb begin
		if (size_q == 4'd0) n_c = NW'(1);
		else if (32'(size_q) > MAX_ORDER) n_c = NW'(MAX_ORDER);
		else n_c = NW'(size_q);
	end

	// full fixed product, saturated
	logic [2*WORD_BITS+1:0] pm_full;
	logic [2*WORD_BITS+1:0] pm_sh;
	logic signed [WORD_BITS-1:0] pm_sat;
	logic pm_neg;
	always_comb begin
		pm_full = (2*WORD_BITS+2)'(magw(lik_q)) * (2*WORD_BITS+2)'(magw(ukj_q));
		pm_sh   = pm_full >> FRAC_BITS;
		pm_neg  = lik_q[WORD_BITS-1] ^ ukj_q[WORD_BITS-1];
		if (pm_neg) begin
			if (pm_sh > (2*WORD_BITS+2)'(magw(WMIN))) pm_sat = WMIN;
			else pm_sat = WORD_BITS'(~pm_sh + 1'b1);
		end else begin
			if (pm_sh > (2*WORD_BITS+2)'(WMAX)) pm_sat = WMAX;
			else pm_sat = WORD_BITS'(pm_sh);
		end
	end

	logic signed [WORD_BITS:0] sub_w;
	logic signed [WORD_BITS-1:0] sub_sat;
	always_comb begin
		sub_w = (WORD_BITS+1)'(t_q) - (WORD_BITS+1)'(prod_q);
		if (sub_w > (WORD_BITS+1)'(WMAX)) sub_sat = WMAX;
		else if (sub_w < (WORD_BITS+1)'(WMIN)) sub_sat = WMIN;
		else sub_sat = WORD_BITS'(sub_w);
	end

	logic acc_in;
	logic out_free;
	assign out_free = !out_valid || !out_stall;
	// a read in flight still owns the output register
	assign in_stall = (st_q != S_IDLE) || rd_pend_s1 || !out_free;
	assign acc_in   = in_valid && !in_stall;

	logic [IW-1:0] last_c;
	assign last_c = IW'(n_c - 1'b1);

	logic signed [WORD_BITS-1:0] vin;
	always_comb begin
		if (WORD_BITS >= 32) vin = WORD_BITS'(value);
		else if (value > 32'(WMAX)) vin = WMAX;
		else if (value < 32'(WMIN)) vin = WMIN;
		else vin = WORD_BITS'(value);
	end

	always_comb begin
		wm_we = 1'b0; lm_we = 1'b0; um_we = 1'b0;
		wm_wa = '0; lm_wa = '0; um_wa = '0;
		wm_wd = '0; lm_wd = '0; um_wd = '0;
		wm_ra = '0; lm_ra = '0; um_ra = '0;
		dctl = '0;
		dctl.busy = (st_q == S_DIV);
		unique case (st_q)
			S_IDLE: begin
				wm_we = acc_in && kind == lu_dec_pkg::KIND_WRITE;
				wm_wa = ad(IW'(row), IW'(col));
				wm_wd = vin;
				lm_ra = ad(IW'(row), IW'(col));
				um_ra = ad(IW'(row), IW'(col));
			end
			S_INIT: begin
				wm_ra = ad(i_q, j_q);
				lm_we = (ph_q == 2'd1);
				um_we = (ph_q == 2'd1);
				lm_wa = ad(i_q, j_q);
				um_wa = ad(i_q, j_q);
				lm_wd = (j_q == i_q) ? ONE : ((j_q < i_q) ? wm_rd : '0);
				um_wd = (j_q >= i_q) ? wm_rd : '0;
			end
			S_SRCH: wm_ra = ad(i_q, k_q);
			S_SWAPA: begin
				wm_ra = ad(k_q, j_q);
				lm_ra = ad(k_q, j_q);
			end
			S_SWAPB: begin
				wm_ra = ad(piv_q, j_q);
				lm_ra = ad(piv_q, j_q);
				wm_we = 1'b1; wm_wa = ad(piv_q, j_q); wm_wd = t_q;
				lm_we = (j_q < k_q); lm_wa = ad(piv_q, j_q); lm_wd = lik_q;
			end
			S_DIAG: begin
				wm_we = 1'b1; wm_wa = ad(k_q, j_q); wm_wd = wm_rd;
				lm_we = (j_q < k_q); lm_wa = ad(k_q, j_q); lm_wd = lm_rd;
				um_we = (j_q >= k_q); um_wa = ad(k_q, j_q); um_wd = wm_rd;
			end
			S_DRD: wm_ra = ad(i_q, k_q);
			S_DIV: begin
				dctl.start = (ph_q == 2'd1);
				lm_we = d_done; lm_wa = ad(i_q, k_q); lm_wd = d_quot;
			end
			S_URD: ;
			S_UPRA: begin
				wm_ra = ad(i_q, j_q);
				lm_ra = ad(i_q, k_q);
				um_ra = ad(k_q, j_q);
			end
			S_UPRB: ;
			S_UPM: ;
			S_UPW: begin
				wm_we = 1'b1; wm_wa = ad(i_q, j_q); wm_wd = sub_sat;
			end
			S_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			size_q <= 4'd8;
			sing_q <= 1'b0;
			out_valid <= 1'b0;
			rd_pend_s1 <= 1'b0;
			k_q <= '0; i_q <= '0; j_q <= '0; piv_q <= '0; ph_q <= '0;
			found_q <= 1'b0;
		end else begin
			if (cfg_we) size_q <= cfg_wdata;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			rd_pend_s1 <= 1'b0;
			if (rd_pend_s1) out_valid <= 1'b1;
			unique case (st_q)
				S_IDLE: begin
					if (acc_in && kind == lu_dec_pkg::KIND_READ) rd_pend_s1 <= 1'b1;
					if (acc_in && kind == lu_dec_pkg::KIND_START) begin
						st_q <= S_INIT;
						i_q <= '0; j_q <= '0; ph_q <= '0;
					end
				end
				S_INIT: begin
					if (ph_q == 2'd0) ph_q <= 2'd1;
					else begin
						ph_q <= 2'd0;
						if (j_q == last_c) begin
							j_q <= '0;
							if (i_q == last_c) begin
								sing_q <= 1'b0;
								k_q <= '0; i_q <= '0;
								st_q <= S_SRCH; found_q <= 1'b0; ph_q <= '0;
							end else i_q <= i_q + 1'b1;
						end else j_q <= j_q + 1'b1;
					end
				end
				S_SRCH: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1; i_q <= k_q; found_q <= 1'b0; best_q <= '0;
					end else if (ph_q == 2'd1) begin
						ph_q <= 2'd2;
					end else if (ph_q == 2'd2) begin
						if (magw(wm_rd) > best_q) begin
							best_q <= magw(wm_rd); piv_q <= i_q; found_q <= 1'b1;
						end
						if (i_q == last_c) begin
							ph_q <= 2'd3;
						end else begin
							ph_q <= 2'd1; i_q <= i_q + 1'b1;
						end
					end else begin
						if (!found_q) begin
							sing_q <= 1'b1;
							st_q <= S_DONE;
						end else begin
							j_q <= '0; ph_q <= '0;
							st_q <= S_SWAPA;
						end
					end
				end
				S_SWAPA: begin
					if (ph_q == 2'd0) ph_q <= 2'd1;
					else begin
						t_q <= wm_rd; lik_q <= lm_rd; ph_q <= 2'd0;
						st_q <= S_SWAPB;
					end
				end
				S_SWAPB: st_q <= S_DIAG;
				S_DIAG: begin
					if (j_q == k_q) diag_q <= wm_rd;
					if (j_q == last_c) begin
						j_q <= '0;
						if (k_q == last_c) st_q <= S_DONE;
						else begin
							i_q <= k_q + 1'b1; ph_q <= '0; st_q <= S_DRD;
						end
					end else begin
						j_q <= j_q + 1'b1; st_q <= S_SWAPA;
					end
				end
				S_DRD: begin
					ph_q <= 2'd1; st_q <= S_DIV;
				end
				S_DIV: begin
					ph_q <= 2'd0;
					if (d_done) begin
						if (i_q == last_c) begin
							i_q <= k_q + 1'b1; j_q <= k_q + 1'b1; st_q <= S_UPRA;
						end else begin
							i_q <= i_q + 1'b1; st_q <= S_DRD;
						end
					end
				end
				S_UPRA: st_q <= S_UPRB;
				S_UPRB: begin
					t_q <= wm_rd; lik_q <= lm_rd; ukj_q <= um_rd; st_q <= S_UPM;
				end
				S_UPM: begin
					prod_q <= pm_sat; st_q <= S_UPW;
				end
				S_UPW: begin
					st_q <= S_UPRA;
					if (j_q == last_c) begin
						j_q <= k_q + 1'b1;
						if (i_q == last_c) begin
							k_q <= k_q + 1'b1; ph_q <= '0; st_q <= S_SRCH;
						end else i_q <= i_q + 1'b1;
					end else j_q <= j_q + 1'b1;
				end
				S_URD: st_q <= S_UPRA;
				S_DONE: begin
					if (out_free) begin
						out_valid <= 1'b1; st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// identity permutation written during init, pivot rows swapped after search
	always_ff @(posedge clk) begin
		if (st_q == S_INIT && j_q == '0 && ph_q == 2'd0) pm_q[i_q] <= i_q;
		if (st_q == S_SRCH && ph_q == 2'd3 && found_q) begin
			pm_q[k_q]   <= pm_q[piv_q];
			pm_q[piv_q] <= pm_q[k_q];
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && acc_in) begin
			rd_ok_s1 <= (NW'(row) < n_c) && (NW'(col) < n_c)
				&& (32'(row) < MAX_ORDER) && (32'(col) < MAX_ORDER);
			rrow_s1 <= IW'(row);
		end
		if (st_q == S_DONE && out_free) begin
			lower_value <= '0; upper_value <= '0; perm_row <= '0;
		end
		if (rd_pend_s1) begin
			if (rd_ok_s1) begin
				lower_value <= o32(lm_rd);
				upper_value <= o32(um_rd);
				perm_row <= 3'(pm_q[rrow_s1]);
			end else begin
				lower_value <= '0; upper_value <= '0; perm_row <= '0;
			end
		end
	end

	assign status = sing_q;

	`LU_ASSERT_IMPL(a_busy_stall, clk, arst_n, (st_q != S_IDLE) |-> in_stall, "input taken while busy")
	`LU_ASSERT_NEXT(a_read_out, clk, arst_n, rd_pend_s1, out_valid, "read result lost")
	`LU_ASSERT_IMPL(a_onehot, clk, arst_n, $onehot(st_q) && (!rd_pend_s1 || st_q == S_IDLE), "bad state")
endmodule
`default_nettype wire
